// File: design/frit_pkg.sv
// Shared types and constants for the focus/rest interval timer.
// No dependencies; imported by frit_step, focus_rest_interval_timer, frit_checker and tb.
package frit_pkg;

	// field widths
	localparam int unsigned MinW     = 10;
	localparam int unsigned StepW    = 8;
	localparam int unsigned MsW      = 32;
	localparam int unsigned ActW     = 3;
	localparam int unsigned TargetW  = 26;
	localparam int unsigned InDataW  = 40;
	localparam int unsigned OutDataW = 56;
	localparam int unsigned CfgAddrW = 2;

	localparam logic [MinW-1:0]  MaxMinutes  = 10'd1023;
	localparam logic [15:0]      MsPerMinute = 16'd60000;

	// configuration register indexes
	localparam logic [CfgAddrW-1:0] CFG_FOCUS_INIT = 2'd0;
	localparam logic [CfgAddrW-1:0] CFG_REST_INIT  = 2'd1;
	localparam logic [CfgAddrW-1:0] CFG_STEP       = 2'd2;

	// configuration reset values
	localparam logic [MinW-1:0]  FocusInitReset = 10'd25;
	localparam logic [MinW-1:0]  RestInitReset  = 10'd5;
	localparam logic [StepW-1:0] StepReset      = 8'd5;

	// action codes
	localparam logic [ActW-1:0] ACT_SYNC = 3'd0;
	localparam logic [ActW-1:0] ACT_INC  = 3'd1;
	localparam logic [ActW-1:0] ACT_DEC  = 3'd2;
	localparam logic [ActW-1:0] ACT_SEL  = 3'd3;
	localparam logic [ActW-1:0] ACT_RST  = 3'd4;
	localparam logic [ActW-1:0] ACT_INIT = 3'd5;

	typedef enum logic [1:0] {
		MODE_FOCUS_SEL = 2'd0,
		MODE_REST_SEL  = 2'd1,
		MODE_FOCUSING  = 2'd2,
		MODE_RESTING   = 2'd3
	} mode_t;

	typedef struct packed {
		mode_t             mode;
		logic              paused;
		logic [MsW-1:0]    elapsed_ms;
		logic [MinW-1:0]   focus_minutes;
		logic [MinW-1:0]   rest_minutes;
		logic [MsW-1:0]    last_time_ms;
	} timer_state_t;

	typedef struct packed {
		logic [MinW-1:0]  focus_init;
		logic [MinW-1:0]  rest_init;
		logic [StepW-1:0] step;
	} timer_cfg_t;

endpackage

// File: design/focus_rest_interval_timer.sv
// Top level of the focus/rest interval timer: stream ports, config, state.
// Depends on frit_pkg and frit_step.
//
// port group  | dir | contents
// s_*         | in  | action words: action, now_ms
// m_*         | out | status words: mode, pause, elapsed, durations, switch flag
// cfg_*       | in  | register writes: focus init, rest init, step
//
// One word per cycle while the output is not stalled. A word sits in the input
// register and then, in a single pass through the step logic, updates the
// timer state and lands in the output register.
// The output register stalls on m_tready; the input register keeps taking
// words while it can move on. arst_n resets state and config and clears valid flags.
module focus_rest_interval_timer (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// [2:0] action, [34:3] now_ms, [39:35] zero
	input  logic [frit_pkg::InDataW-1:0]      s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [1:0] mode_now, [2] is_paused, [34:3] elapsed_now_ms,
	// [44:35] focus_now_minutes, [54:45] rest_now_minutes, [55] phase_switched
	output logic [frit_pkg::OutDataW-1:0]     m_tdata,
	input  logic                              cfg_we,
	input  logic [frit_pkg::CfgAddrW-1:0]     cfg_addr,
	input  logic [frit_pkg::MinW-1:0]         cfg_wdata
);
	import frit_pkg::*;

	timer_cfg_t          cfg_q;
	timer_state_t        state_q;
	timer_state_t        state_nxt;
	logic                switched;
	logic                valid_s1;
	logic [ActW-1:0]     action_s1;
	logic [MsW-1:0]      now_s1;
	logic                out_valid_q;
	logic [OutDataW-1:0] out_data_q;
	logic                advance;

	// stage moves when its word has room in the output register
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.focus_init <= FocusInitReset;
			cfg_q.rest_init  <= RestInitReset;
			cfg_q.step       <= StepReset;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				CFG_FOCUS_INIT: cfg_q.focus_init <= cfg_wdata;
				CFG_REST_INIT:  cfg_q.rest_init  <= cfg_wdata;
				CFG_STEP:       cfg_q.step       <= cfg_wdata[StepW-1:0];
				default:        cfg_q            <= cfg_q;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			action_s1 <= s_tdata[ActW-1:0];
			now_s1    <= s_tdata[ActW+MsW-1:ActW];
		end
	end

	frit_step u_step (
		.cur      (state_q),
		.cfg      (cfg_q),
		.action   (action_s1),
		.now_ms   (now_s1),
		.nxt      (state_nxt),
		.switched (switched)
	);

	// timer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode          <= MODE_FOCUS_SEL;
			state_q.paused        <= 1'b1;
			state_q.elapsed_ms    <= '0;
			state_q.focus_minutes <= FocusInitReset;
			state_q.rest_minutes  <= RestInitReset;
			state_q.last_time_ms  <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= {switched, state_nxt.rest_minutes, state_nxt.focus_minutes,
			               state_nxt.elapsed_ms, state_nxt.paused, state_nxt.mode};
		end
	end

	// a phase switch always reports a cleared elapsed count
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[55]) |-> (m_tdata[34:3] == '0))
		else $error("phase switch with nonzero elapsed time");

	// a phase switch leaves the timer in a running mode
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[55]) |-> m_tdata[1])
		else $error("phase switch reported outside running modes");

	// select modes are always paused
	assert property (@(posedge clk) disable iff (!arst_n)
		((state_q.mode == MODE_FOCUS_SEL) || (state_q.mode == MODE_REST_SEL))
		|-> state_q.paused)
		else $error("select mode without pause");

	// a word leaving the input stage shows up at the output next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> m_tvalid)
		else $error("word lost between stages");

endmodule

// File: design/frit_step.sv
// Next-state logic of the interval timer for one action word.
// Depends on frit_pkg; purely combinational, instantiated by the top level.
module frit_step (
	input  frit_pkg::timer_state_t  cur,
	input  frit_pkg::timer_cfg_t    cfg,
	input  logic [frit_pkg::ActW-1:0] action,
	input  logic [frit_pkg::MsW-1:0]  now_ms,
	output frit_pkg::timer_state_t  nxt,
	output logic                    switched
);
	import frit_pkg::*;

	logic                running;
	logic [MinW-1:0]     phase_min;
	logic [TargetW-1:0]  target_ms;
	logic [MsW-1:0]      diff_ms;
	logic [MsW:0]        sum_wide;
	logic [MsW-1:0]      sum_ms;
	logic [MinW-1:0]     sel_min;
	logic [MinW:0]       inc_wide;
	logic [MinW-1:0]     inc_min;
	logic [MinW-1:0]     dec_min;
	logic [MinW-1:0]     adj_min;

	assign running = (cur.mode == MODE_FOCUSING) || (cur.mode == MODE_RESTING);

	// phase length in ms, 10 x 16 bit product
	assign phase_min = (cur.mode == MODE_FOCUSING) ? cur.focus_minutes : cur.rest_minutes;
	assign target_ms = {{(TargetW-MinW){1'b0}}, phase_min} *
	                   {{(TargetW-16){1'b0}}, MsPerMinute};

	// wrapped time delta, saturating accumulate
	assign diff_ms  = now_ms - cur.last_time_ms;
	assign sum_wide = {1'b0, cur.elapsed_ms} + {1'b0, diff_ms};
	assign sum_ms   = sum_wide[MsW] ? {MsW{1'b1}} : sum_wide[MsW-1:0];

	// saturating minute adjust of the selected duration
	assign sel_min  = (cur.mode == MODE_FOCUS_SEL) ? cur.focus_minutes : cur.rest_minutes;
	assign inc_wide = {1'b0, sel_min} + {3'b000, cfg.step};
	assign inc_min  = inc_wide[MinW] ? MaxMinutes : inc_wide[MinW-1:0];
	assign dec_min  = ({2'b00, cfg.step} > sel_min) ? '0 : sel_min - {2'b00, cfg.step};
	assign adj_min  = (action == ACT_INC) ? inc_min : dec_min;

	always_comb begin
		nxt      = cur;
		switched = 1'b0;
		unique case (action)
			ACT_SYNC: begin
				if (running && !cur.paused) begin
					nxt.last_time_ms = now_ms;
					if (sum_ms >= {{(MsW-TargetW){1'b0}}, target_ms}) begin
						nxt.mode       = (cur.mode == MODE_FOCUSING) ? MODE_RESTING
						                                             : MODE_FOCUSING;
						nxt.elapsed_ms = '0;
						switched       = 1'b1;
					end else begin
						nxt.elapsed_ms = sum_ms;
					end
				end
			end
			ACT_INC, ACT_DEC: begin
				if (cur.mode == MODE_FOCUS_SEL) begin
					nxt.focus_minutes = adj_min;
				end else if (cur.mode == MODE_REST_SEL) begin
					nxt.rest_minutes = adj_min;
				end
			end
			ACT_SEL: begin
				unique case (cur.mode)
					MODE_FOCUS_SEL: begin
						nxt.mode = MODE_REST_SEL;
					end
					MODE_REST_SEL: begin
						nxt.mode         = MODE_FOCUSING;
						nxt.paused       = 1'b0;
						nxt.last_time_ms = now_ms;
						nxt.elapsed_ms   = '0;
					end
					MODE_FOCUSING, MODE_RESTING: begin
						nxt.paused       = ~cur.paused;
						nxt.last_time_ms = now_ms;
					end
				endcase
			end
			ACT_RST, ACT_INIT: begin
				nxt.mode         = MODE_FOCUS_SEL;
				nxt.paused       = 1'b1;
				nxt.elapsed_ms   = '0;
				nxt.last_time_ms = now_ms;
				if (action == ACT_INIT) begin
					nxt.focus_minutes = cfg.focus_init;
					nxt.rest_minutes  = cfg.rest_init;
				end
			end
			default: begin
				// unused action codes leave the state alone
				nxt = cur;
			end
		endcase
	end

endmodule

// File: tb/frit_checker.sv
`timescale 1ns / 1ps
// Checker for the focus/rest interval timer: watches the action and status streams
// and the register write port, predicts every status word and compares it per field.
// Depends on frit_pkg.
module frit_checker
	import frit_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	input  logic                s_tready,
	// [2:0] action, [34:3] now_ms, [39:35] zero
	input  logic [InDataW-1:0]  s_tdata,
	input  logic                m_tvalid,
	input  logic                m_tready,
	// [1:0] mode_now, [2] is_paused, [34:3] elapsed_now_ms,
	// [44:35] focus_now_minutes, [54:45] rest_now_minutes, [55] phase_switched
	input  logic [OutDataW-1:0] m_tdata,
	input  logic                cfg_we,
	input  logic [CfgAddrW-1:0] cfg_addr,
	input  logic [MinW-1:0]     cfg_wdata,
	output int unsigned         fail_count,
	output int unsigned         pending_count,
	output int unsigned         checked_count,
	output int unsigned         switch_count
);

	// status word, first member in the top bits
	typedef struct packed {
		logic            switched;
		logic [MinW-1:0] rest;
		logic [MinW-1:0] focus;
		logic [MsW-1:0]  elapsed;
		logic            paused;
		mode_t           mode;
	} status_t;

	// predicted timer state and register copies
	mode_t            mode_q;
	logic             paused_q;
	logic [MsW-1:0]   elapsed_q;
	logic [MsW-1:0]   last_ms_q;
	logic [MinW-1:0]  focus_q;
	logic [MinW-1:0]  rest_q;
	logic [MinW-1:0]  focus_init_q;
	logic [MinW-1:0]  rest_init_q;
	logic [StepW-1:0] step_q;

	status_t     awaited_status[$];
	int unsigned mismatch_count;

	// duration adjust, clamped to the legal minute range
	function automatic logic [MinW-1:0] minutes_up(input logic [MinW-1:0] mins);
		logic [MinW:0] grown;
		grown = mins + step_q;
		return (grown > MaxMinutes) ? MaxMinutes : grown[MinW-1:0];
	endfunction

	function automatic logic [MinW-1:0] minutes_down(input logic [MinW-1:0] mins);
		return (step_q > mins) ? '0 : mins - step_q;
	endfunction

	// apply one action word to the timer state, return the status it reports
	function automatic status_t timer_next_status(input logic [ActW-1:0] act,
		input logic [MsW-1:0] now);
		logic [MsW:0]    sum;
		logic [MsW-1:0]  target;
		logic [MinW-1:0] mins;
		status_t         st;
		st.switched = 1'b0;
		case (act)
			ACT_SYNC: begin
				if ((mode_q == MODE_FOCUSING || mode_q == MODE_RESTING) && !paused_q) begin
					mins = (mode_q == MODE_FOCUSING) ? focus_q : rest_q;
					target = MsW'(mins) * MsW'(MsPerMinute);
					sum = {1'b0, elapsed_q} + {1'b0, now - last_ms_q};
					// elapsed time sticks at all ones rather than wrapping
					elapsed_q = sum[MsW] ? '1 : sum[MsW-1:0];
					last_ms_q = now;
					if (elapsed_q >= target) begin
						mode_q = (mode_q == MODE_FOCUSING) ? MODE_RESTING : MODE_FOCUSING;
						elapsed_q = '0;
						st.switched = 1'b1;
					end
				end
			end
			ACT_INC: begin
				if (mode_q == MODE_FOCUS_SEL)
					focus_q = minutes_up(focus_q);
				else if (mode_q == MODE_REST_SEL)
					rest_q = minutes_up(rest_q);
			end
			ACT_DEC: begin
				if (mode_q == MODE_FOCUS_SEL)
					focus_q = minutes_down(focus_q);
				else if (mode_q == MODE_REST_SEL)
					rest_q = minutes_down(rest_q);
			end
			ACT_SEL: begin
				if (mode_q == MODE_FOCUS_SEL) begin
					mode_q = MODE_REST_SEL;
				end else if (mode_q == MODE_REST_SEL) begin
					mode_q = MODE_FOCUSING;
					paused_q = 1'b0;
					last_ms_q = now;
					elapsed_q = '0;
				end else begin
					paused_q = ~paused_q;
					last_ms_q = now;
				end
			end
			ACT_RST, ACT_INIT: begin
				if (act == ACT_INIT) begin
					focus_q = focus_init_q;
					rest_q = rest_init_q;
				end
				mode_q = MODE_FOCUS_SEL;
				paused_q = 1'b1;
				elapsed_q = '0;
				last_ms_q = now;
			end
			default: begin
			end
		endcase
		st.mode = mode_q;
		st.paused = paused_q;
		st.elapsed = elapsed_q;
		st.focus = focus_q;
		st.rest = rest_q;
		return st;
	endfunction

	// watch the channels; results are compared before new words are predicted
	always @(posedge clk or negedge arst_n) begin
		status_t seen;
		status_t want;
		if (!arst_n) begin
			focus_init_q = FocusInitReset;
			rest_init_q = RestInitReset;
			step_q = StepReset;
			focus_q = FocusInitReset;
			rest_q = RestInitReset;
			mode_q = MODE_FOCUS_SEL;
			paused_q = 1'b1;
			elapsed_q = '0;
			last_ms_q = '0;
			awaited_status.delete();
			fail_count = 0;
			mismatch_count = 0;
			pending_count = 0;
			checked_count = 0;
			switch_count = 0;
		end else begin
			// register writes
			if (cfg_we) begin
				case (cfg_addr)
					CFG_FOCUS_INIT: focus_init_q = cfg_wdata;
					CFG_REST_INIT:  rest_init_q = cfg_wdata;
					CFG_STEP:       step_q = cfg_wdata[StepW-1:0];
					default: begin
					end
				endcase
			end
			// status words out
			if (m_tvalid && m_tready) begin
				seen = status_t'(m_tdata);
				checked_count++;
				if (awaited_status.size() == 0) begin
					fail_count++;
					if (mismatch_count < 10)
						$display("unexpected status word %h at %0t", m_tdata, $realtime);
					mismatch_count++;
				end else begin
					want = awaited_status.pop_front();
					if (seen.mode !== want.mode || seen.paused !== want.paused ||
						seen.elapsed !== want.elapsed || seen.focus !== want.focus ||
						seen.rest !== want.rest || seen.switched !== want.switched) begin
						fail_count++;
						if (mismatch_count < 10) begin
							$display("status word %0d mismatch at %0t", checked_count, $realtime);
							$display("  expected mode %0d paused %0b elapsed %0d focus %0d rest %0d switched %0b",
								want.mode, want.paused, want.elapsed, want.focus, want.rest,
								want.switched);
							$display("  actual   mode %0d paused %0b elapsed %0d focus %0d rest %0d switched %0b",
								seen.mode, seen.paused, seen.elapsed, seen.focus, seen.rest,
								seen.switched);
						end
						mismatch_count++;
					end
				end
			end
			// action words in
			if (s_tvalid && s_tready) begin
				want = timer_next_status(s_tdata[ActW-1:0], s_tdata[ActW+MsW-1:ActW]);
				if (want.switched)
					switch_count++;
				awaited_status.push_back(want);
			end
			pending_count = awaited_status.size();
		end
	end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// Testbench top for the focus/rest interval timer: clock, reset, action word stimulus,
// register writes and verdict. Depends on frit_pkg, frit_checker and the timer RTL.
module tb;
	import frit_pkg::*;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [InDataW-1:0]  s_tdata;
	logic                m_tvalid;
	logic                m_tready;
	logic [OutDataW-1:0] m_tdata;
	logic                cfg_we;
	logic [CfgAddrW-1:0] cfg_addr;
	logic [MinW-1:0]     cfg_wdata;

	int unsigned fail_count;
	int unsigned pending_count;
	int unsigned checked_count;
	int unsigned switch_count;

	int unsigned send_idle_pct = 35;
	int unsigned recv_idle_pct = 73;
	int unsigned hold_cycles = 0;
	int unsigned word_count = 0;
	logic [MsW-1:0] clock_ms = '0;

	focus_rest_interval_timer DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	frit_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.fail_count    (fail_count),
		.pending_count (pending_count),
		.checked_count (checked_count),
		.switch_count  (switch_count)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// run limit
	initial begin
		#2_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// status word receiver: random stalls, or a long hold-off on request
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles != 0) begin
				m_tready = 1'b0;
				repeat (hold_cycles) @(negedge clk);
				hold_cycles = 0;
			end
			m_tready = ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// offer one action word, entered and left at a falling edge
	task automatic send_word(input logic [ActW-1:0] act, input logic [MsW-1:0] now);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = {{(InDataW-ActW-MsW){1'b0}}, now, act};
		do begin
			@(posedge clk);
		end while (!s_tready);
		@(negedge clk);
		s_tvalid = 1'b0;
		word_count++;
	endtask

	task automatic write_reg(input logic [CfgAddrW-1:0] idx, input logic [MinW-1:0] val);
		cfg_we = 1'b1;
		cfg_addr = idx;
		cfg_wdata = val;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// hold the sender until every status word is back and the pipe is empty
	task automatic drain();
		while (pending_count != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// mostly short ticks, some long gaps, a few huge jumps that wrap the clock
	task automatic advance_clock();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 80)
			clock_ms += $urandom_range(0, 90000);
		else if (r < 95)
			clock_ms += $urandom_range(0, 4000000);
		else
			clock_ms += $urandom();
	endtask

	// one session: init, pick durations, start, run with ticks, pauses and stray words
	task automatic run_session();
		int unsigned r;
		send_word(ACT_INIT, clock_ms);
		repeat ($urandom_range(0, 3))
			send_word($urandom_range(0, 1) ? ACT_INC : ACT_DEC, clock_ms);
		send_word(ACT_SEL, clock_ms);
		repeat ($urandom_range(0, 3))
			send_word($urandom_range(0, 1) ? ACT_INC : ACT_DEC, clock_ms);
		advance_clock();
		send_word(ACT_SEL, clock_ms);
		repeat ($urandom_range(6, 20)) begin
			r = $urandom_range(0, 99);
			if (r < 70) begin
				advance_clock();
				send_word(ACT_SYNC, clock_ms);
			end else if (r < 80) begin
				advance_clock();
				send_word(ACT_SEL, clock_ms);
			end else if (r < 88) begin
				send_word($urandom_range(0, 1) ? ACT_INC : ACT_DEC, clock_ms);
			end else begin
				send_word(ActW'($urandom_range(0, 7)), $urandom());
			end
		end
		if ($urandom_range(0, 3) == 0)
			send_word(ACT_RST, clock_ms);
	endtask

	// stimulus and verdict
	initial begin
		int unsigned quota;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_we = 1'b0;
		cfg_addr = CFG_FOCUS_INIT;
		cfg_wdata = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: saturation both ways, zero durations, running and paused cases
		write_reg(CFG_STEP, 10'd255);
		repeat (4) send_word(ACT_INC, 32'd0);
		repeat (5) send_word(ACT_DEC, 32'd0);
		send_word(ACT_SEL, 32'd0);
		send_word(ACT_INC, 32'd0);
		repeat (2) send_word(ACT_DEC, 32'd0);
		send_word(ACT_SEL, 32'd1000);
		send_word(ACT_SYNC, 32'd1000);
		send_word(ACT_SYNC, 32'd1005);
		send_word(ACT_INC, 32'd1010);
		send_word(ACT_DEC, 32'd1010);
		send_word(ACT_SEL, 32'd2000);
		send_word(ACT_SYNC, 32'd5000);
		send_word(ACT_SEL, 32'd6000);
		send_word(3'd6, 32'hAAAA_5555);
		send_word(ACT_RST, 32'hFFFF_FFFF);
		send_word(ACT_INIT, 32'd0);
		// elapsed sum overflow: a full-wrap tick after some elapsed time
		send_word(ACT_SEL, 32'd0);
		send_word(ACT_SEL, 32'd0);
		send_word(ACT_SYNC, 32'd60000);
		send_word(ACT_SYNC, 32'd59999);

		// random sessions under several register settings and idle patterns
		for (int ph = 0; ph < 6; ph++) begin
			if (ph == 2) begin
				send_idle_pct = 73;
				recv_idle_pct = 35;
			end else if (ph == 4) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			drain();
			case (ph)
				0: begin
					write_reg(CFG_FOCUS_INIT, 10'd1);
					write_reg(CFG_REST_INIT, 10'd2);
					write_reg(CFG_STEP, 10'd1);
				end
				1: begin
					write_reg(CFG_FOCUS_INIT, 10'd0);
					write_reg(CFG_REST_INIT, 10'd0);
					write_reg(CFG_STEP, 10'd0);
				end
				2: begin
					write_reg(CFG_FOCUS_INIT, 10'd1023);
					write_reg(CFG_REST_INIT, 10'd1023);
					write_reg(CFG_STEP, 10'd255);
				end
				3: begin
					write_reg(CFG_FOCUS_INIT, 10'd3);
					write_reg(CFG_REST_INIT, 10'd1);
					write_reg(CFG_STEP, 10'd2);
				end
				4: begin
					write_reg(CFG_FOCUS_INIT, MinW'($urandom_range(0, 4)));
					write_reg(CFG_REST_INIT, MinW'($urandom_range(0, 4)));
					write_reg(CFG_STEP, MinW'($urandom_range(0, 3)));
				end
				default: begin
					write_reg(CFG_FOCUS_INIT, MinW'($urandom_range(0, 1023)));
					write_reg(CFG_REST_INIT, MinW'($urandom_range(0, 1023)));
					write_reg(CFG_STEP, MinW'($urandom_range(0, 255)));
				end
			endcase
			// long receiver hold-off while words keep coming
			if (ph == 0 || ph == 4)
				hold_cycles = 60;
			quota = word_count + 170;
			while (word_count < quota) begin
				if ($urandom_range(0, 4) == 0)
					repeat ($urandom_range(1, 4))
						send_word(ActW'($urandom_range(0, 7)), $urandom());
				if ($urandom_range(0, 7) == 0)
					clock_ms = $urandom();
				run_session();
			end
		end

		// wait for the last status words
		while (pending_count != 0) @(negedge clk);
		repeat (6) @(negedge clk);
		$display("sent %0d action words over 6 register settings and 3 idle patterns",
			word_count);
		$display("checked %0d status words, %0d of them phase switches",
			checked_count, switch_count);
		if (fail_count == 0 && pending_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
